// ----- design/wsf_pkg.sv -----
`default_nettype none
package wsf_pkg;
   localparam int PIX_W   = 16;
   localparam int WGT_W   = 8;
   localparam int DIM_W   = 11;
   localparam int CHK_W   = 36;
   localparam int ACC_W   = 28;   // 9 * 255 * 65535 fits
   localparam int WSUM_W  = 12;   // 9 * 255 fits
   localparam int CNT_W   = 5;    // counts ACC_W divide steps
   localparam int SZC_W   = 14;   // compare width for clamping sizes
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_ROWS   = 3'd0;
   localparam logic [IDX_W-1:0] REG_COLS   = 3'd1;
   localparam logic [IDX_W-1:0] REG_CENTRE = 3'd2;
   localparam logic [IDX_W-1:0] REG_SIDE   = 3'd3;
   localparam logic [IDX_W-1:0] REG_CORNER = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_LAST, ST_DIV, ST_WAIT, ST_OUT, ST_FIX, ST_FIXW
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// ----- design/weighted_3x3_smoothing_filter.sv -----
`default_nettype none
// channel | dir | payload (low bit up)                          | accept
// req     | in  | tdata: pixel[15:0]; tuser: mode               | tvalid & tready
// rsp     | out | tdata: filtered_value, running_checksum, 0-pad; | tvalid & tready
//         |     | tlast: frame_last                              |
// csr     | in  | csr_idx selects register, csr_wdata value      | csr_we
//
// an item that gives no result is just accepted; one that gives a result passes
// the accept, nine reads of the pixel history, the last sum and divider start,
// the bit-serial divider (28 quotient bits and done), then the output load
// a column count write holds req_tready low while the divider rebuilds
// row and column of the output position
// reset is synchronous; the pixel history is not cleared, counters are
// a finished result waits in the output register while the next item is taken
// req_tready drops while a neighborhood is being read and divided
module weighted_3x3_smoothing_filter #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // pixel[15:0]
   input  wire  [0:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [55:0]  rsp_tdata,   // filtered_value[15:0], running_checksum[51:16]
   output logic         rsp_tlast,
   input  wire          csr_we,
   input  wire  [wsf_pkg::IDX_W-1:0] csr_idx,
   input  wire  [wsf_pkg::DIM_W-1:0] csr_wdata
);
   localparam int HIST  = 2 * MAX_COLS + 3;
   localparam int HA_W  = $clog2(HIST);
   localparam int AS_W  = HA_W + 2;
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int POS_W = $clog2(MAX_ROWS * MAX_COLS + 1);

   // configuration registers
   logic [wsf_pkg::DIM_W-1:0] row_count_ff, col_count_ff;
   logic [wsf_pkg::WGT_W-1:0] cw_ff, sw_ff, kw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= wsf_pkg::DIM_W'(1024);
         col_count_ff <= wsf_pkg::DIM_W'(1024);
         cw_ff <= wsf_pkg::WGT_W'(1);
         sw_ff <= wsf_pkg::WGT_W'(1);
         kw_ff <= wsf_pkg::WGT_W'(1);
      end else if (csr_we) begin
         case (csr_idx)
            wsf_pkg::REG_ROWS:   row_count_ff <= csr_wdata;
            wsf_pkg::REG_COLS:   col_count_ff <= csr_wdata;
            wsf_pkg::REG_CENTRE: cw_ff <= csr_wdata[wsf_pkg::WGT_W-1:0];
            wsf_pkg::REG_SIDE:   sw_ff <= csr_wdata[wsf_pkg::WGT_W-1:0];
            wsf_pkg::REG_CORNER: kw_ff <= csr_wdata[wsf_pkg::WGT_W-1:0];
            default: ;
         endcase
      end
   end

   // frame size, clamped to 1..max
   logic [wsf_pkg::SZC_W-1:0] rows_x, cols_x;
   logic [RW-1:0]             rows_eff;
   logic [CW-1:0]             cols_eff;
   logic [POS_W-1:0]          total;

   assign rows_x = wsf_pkg::SZC_W'(row_count_ff);
   assign cols_x = wsf_pkg::SZC_W'(col_count_ff);
   assign rows_eff = (rows_x == '0) ? RW'(1) :
                     (rows_x > wsf_pkg::SZC_W'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_x);
   assign cols_eff = (cols_x == '0) ? CW'(1) :
                     (cols_x > wsf_pkg::SZC_W'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_x);
   assign total = POS_W'(rows_eff * cols_eff);

   // frame state
   wsf_pkg::state_type          state_ff, state_in;
   logic [POS_W-1:0]            in_pos_ff, out_pos_ff;
   logic [HA_W-1:0]             wp_ff, qa_ff;
   logic [RW-1:0]               r_ff;
   logic [CW-1:0]               c_ff;
   logic [wsf_pkg::CHK_W-1:0]   chk_ff;
   logic [1:0]                  dr_ff, dc_ff;
   logic                        pend_ff;
   logic [wsf_pkg::WGT_W-1:0]   wt_ff;
   logic [wsf_pkg::ACC_W-1:0]   acc_ff;
   logic [wsf_pkg::WSUM_W-1:0]  wsum_ff;
   logic [wsf_pkg::PIX_W-1:0]   val_ff;
   logic                        rsp_valid_ff, rsp_last_ff;
   logic [wsf_pkg::PIX_W-1:0]   rsp_val_ff;
   logic [wsf_pkg::CHK_W-1:0]   rsp_chk_ff;
   // a column count change mid-frame needs row and column rebuilt
   logic                        fix_req_ff, fix_req_in, fix_done;

   // accept path: restart the frame if the last result has gone out
   logic                        newf, acc_go, is_drain, wr_en, emit, fin, load;
   logic [POS_W-1:0]            ip, op, ip_nx;
   logic [HA_W-1:0]             wpa, qa, wp_nx;
   logic [RW-1:0]               rr;
   logic [CW-1:0]               cc;
   logic [wsf_pkg::CHK_W-1:0]   chk;

   always_comb begin
      newf     = out_pos_ff >= total;
      ip       = newf ? '0 : in_pos_ff;
      op       = newf ? '0 : out_pos_ff;
      wpa      = newf ? '0 : wp_ff;
      qa       = newf ? '0 : qa_ff;
      rr       = newf ? '0 : r_ff;
      cc       = newf ? '0 : c_ff;
      chk      = newf ? '0 : chk_ff;
      is_drain = req_tuser[0];
      acc_go   = (state_ff == wsf_pkg::ST_IDLE) && req_tvalid && !fix_req_ff;
      wr_en    = acc_go && !is_drain && (ip < total);
      ip_nx    = wr_en ? ip + 1'b1 : ip;
      wp_nx    = !wr_en ? wpa : (wpa == HA_W'(HIST - 1)) ? '0 : wpa + 1'b1;
      if (is_drain) begin
         emit = acc_go && (ip >= total);
      end else begin
         emit = wr_en && ((POS_W+1)'(op) + (POS_W+1)'(cols_eff) + (POS_W+1)'(2)
                          <= (POS_W+1)'(ip_nx));
      end
   end

   // neighbor address and weight for the current read step
   logic [AS_W-1:0]            t_addr;
   logic [HA_W-1:0]            rd_addr;
   logic                       nb_ok, rd_en;
   logic [wsf_pkg::WGT_W-1:0]  nb_w;
   logic [wsf_pkg::PIX_W-1:0]  rd_data;

   always_comb begin
      t_addr = AS_W'(qa_ff);
      case (dr_ff)
         2'd0:    t_addr = t_addr - AS_W'(cols_eff);
         2'd2:    t_addr = t_addr + AS_W'(cols_eff);
         default: ;
      endcase
      case (dc_ff)
         2'd0:    t_addr = t_addr - 1'b1;
         2'd2:    t_addr = t_addr + 1'b1;
         default: ;
      endcase
      // one wrap step is enough: offsets stay below the history depth
      if (t_addr[AS_W-1]) begin
         rd_addr = HA_W'(t_addr + AS_W'(HIST));
      end else if (t_addr >= AS_W'(HIST)) begin
         rd_addr = HA_W'(t_addr - AS_W'(HIST));
      end else begin
         rd_addr = HA_W'(t_addr);
      end
      nb_ok = (dr_ff != 2'd0 || r_ff != '0) && (dr_ff != 2'd2 || r_ff != rows_eff - 1'b1)
           && (dc_ff != 2'd0 || c_ff != '0) && (dc_ff != 2'd2 || c_ff != cols_eff - 1'b1);
      if (dr_ff == 2'd1 && dc_ff == 2'd1) begin
         nb_w = cw_ff;
      end else if (dr_ff == 2'd1 || dc_ff == 2'd1) begin
         nb_w = sw_ff;
      end else begin
         nb_w = kw_ff;
      end
      rd_en = state_ff == wsf_pkg::ST_READ;
   end

   wsf_hist #(.DEPTH(HIST), .AW(HA_W)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpa),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wsf_pkg::div_stat_type      div_stat;
   logic [wsf_pkg::ACC_W-1:0]  quotient;
   logic [wsf_pkg::WSUM_W-1:0] div_rem;
   logic                       div_start;
   logic [wsf_pkg::ACC_W-1:0]  div_dvd;
   logic [wsf_pkg::WSUM_W-1:0] div_dvs;

   // the divider also splits the output position into row and column
   assign div_dvd = (state_ff == wsf_pkg::ST_FIX) ? wsf_pkg::ACC_W'(out_pos_ff) : acc_ff;
   assign div_dvs = (state_ff == wsf_pkg::ST_FIX) ? wsf_pkg::WSUM_W'(cols_eff) : wsum_ff;

   wsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .stat      (div_stat),
      .quotient  (quotient),
      .remainder (div_rem)
   );

   // control
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load      = 1'b0;
      fix_done  = 1'b0;
      case (state_ff)
         wsf_pkg::ST_IDLE: begin
            if (fix_req_ff) state_in = wsf_pkg::ST_FIX;
            else if (emit) state_in = wsf_pkg::ST_READ;
         end
         wsf_pkg::ST_READ: if (dr_ff == 2'd2 && dc_ff == 2'd2) state_in = wsf_pkg::ST_LAST;
         wsf_pkg::ST_LAST: state_in = wsf_pkg::ST_DIV;
         wsf_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = wsf_pkg::ST_WAIT;
         end
         wsf_pkg::ST_WAIT: if (div_stat.done) state_in = wsf_pkg::ST_OUT;
         wsf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = wsf_pkg::ST_IDLE;
            end
         end
         wsf_pkg::ST_FIX: begin
            div_start = 1'b1;
            state_in  = wsf_pkg::ST_FIXW;
         end
         wsf_pkg::ST_FIXW: begin
            if (div_stat.done) begin
               fix_done = 1'b1;
               state_in = wsf_pkg::ST_IDLE;
            end
         end
         default: state_in = wsf_pkg::ST_IDLE;
      endcase
      fin = (out_pos_ff + 1'b1) == total;
      // a new column write requests another rebuild
      fix_req_in = (csr_we && csr_idx == wsf_pkg::REG_COLS)
                || (fix_req_ff && state_ff != wsf_pkg::ST_IDLE);
   end

   assign req_tready = (state_ff == wsf_pkg::ST_IDLE) && !fix_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wsf_pkg::ST_IDLE;
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         wp_ff      <= '0;
         qa_ff      <= '0;
         r_ff       <= '0;
         c_ff       <= '0;
         chk_ff     <= '0;
         dr_ff      <= '0;
         dc_ff      <= '0;
         pend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fix_req_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
         rsp_valid_ff <= load || (rsp_valid_ff && !rsp_tready);
         fix_req_ff <= fix_req_in;
         if (acc_go) begin
            in_pos_ff  <= ip_nx;
            out_pos_ff <= op;
            wp_ff      <= wp_nx;
            qa_ff      <= qa;
            r_ff       <= rr;
            c_ff       <= cc;
            chk_ff     <= chk;
            dr_ff      <= '0;
            dc_ff      <= '0;
         end
         if (fix_done) begin
            r_ff <= RW'(quotient);
            c_ff <= CW'(div_rem);
         end
         if (rd_en) begin
            if (dc_ff == 2'd2) begin
               dc_ff <= '0;
               dr_ff <= dr_ff + 1'b1;
            end else begin
               dc_ff <= dc_ff + 1'b1;
            end
         end
         if (load) begin
            if (fin) begin
               // frame done, next item starts a new one
               in_pos_ff  <= '0;
               out_pos_ff <= '0;
               wp_ff      <= '0;
               qa_ff      <= '0;
               r_ff       <= '0;
               c_ff       <= '0;
               chk_ff     <= '0;
            end else begin
               out_pos_ff <= out_pos_ff + 1'b1;
               qa_ff      <= (qa_ff == HA_W'(HIST - 1)) ? '0 : qa_ff + 1'b1;
               chk_ff     <= chk_ff + wsf_pkg::CHK_W'(val_ff);
               if (c_ff == cols_eff - 1'b1) begin
                  c_ff <= '0;
                  r_ff <= r_ff + 1'b1;
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
         end
      end
   end

   // datapath: weighted sum over the window, one neighbor a cycle
   always_ff @(posedge clock) begin
      wt_ff <= nb_ok ? nb_w : '0;
      if (acc_go) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (pend_ff && wt_ff != '0) begin
         acc_ff  <= acc_ff + wsf_pkg::ACC_W'(wt_ff * rd_data);
         wsum_ff <= wsum_ff + wsf_pkg::WSUM_W'(wt_ff);
      end
      if (div_stat.done && state_ff == wsf_pkg::ST_WAIT) begin
         val_ff <= (wsum_ff == '0) ? '0 : quotient[wsf_pkg::PIX_W-1:0];
      end
      if (load) begin
         rsp_val_ff  <= val_ff;
         rsp_chk_ff  <= chk_ff + wsf_pkg::CHK_W'(val_ff);
         rsp_last_ff <= fin;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_chk_ff, rsp_val_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      out_pos_ff <= in_pos_ff) else $error("output ahead of input");
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff < HA_W'(HIST)) else $error("write pointer out of range");
   a_qa_range: assert property (@(posedge clock) disable iff (reset)
      qa_ff < HA_W'(HIST)) else $error("output address out of range");
endmodule
`default_nettype wire

// ----- design/wsf_hist.sv -----
`default_nettype none
module wsf_hist #(
   parameter int DEPTH = 2051,
   parameter int AW    = 12
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [AW-1:0]                wr_addr,
   input  wire  [wsf_pkg::PIX_W-1:0]    wr_data,
   input  wire                          rd_en,
   input  wire  [AW-1:0]                rd_addr,
   output logic [wsf_pkg::PIX_W-1:0]    rd_data
);
   logic [wsf_pkg::PIX_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- design/wsf_div.sv -----
`default_nettype none
module wsf_div (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire  [wsf_pkg::ACC_W-1:0]         dividend,
   input  wire  [wsf_pkg::WSUM_W-1:0]        divisor,
   output wsf_pkg::div_stat_type             stat,
   output logic [wsf_pkg::ACC_W-1:0]         quotient,
   output logic [wsf_pkg::WSUM_W-1:0]        remainder
);
   logic                         busy_ff, done_ff;
   logic [wsf_pkg::CNT_W-1:0]    cnt_ff;
   logic [wsf_pkg::ACC_W-1:0]    quo_ff;
   logic [wsf_pkg::WSUM_W-1:0]   rem_ff, dvs_ff;
   logic [wsf_pkg::WSUM_W:0]     trial;
   logic                         ge;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[wsf_pkg::ACC_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == wsf_pkg::CNT_W'(wsf_pkg::ACC_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? wsf_pkg::WSUM_W'(trial - {1'b0, dvs_ff})
                      : wsf_pkg::WSUM_W'(trial);
         quo_ff <= {quo_ff[wsf_pkg::ACC_W-2:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divide done without run");
endmodule
`default_nettype wire
